### src/spi_buffer_exchange_engine_macros.svh
// ----------------------------------------------------------------------------
// SPI buffer exchange engine assertion macros
// Shared forms for the concurrent checks of the exchange engine.
// ----------------------------------------------------------------------------
`ifndef SPI_BUFFER_EXCHANGE_ENGINE_MACROS_SVH
`define SPI_BUFFER_EXCHANGE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPIBX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spibx check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPIBX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spibx check failed");

`endif

### src/spibx_pkg.sv
// ----------------------------------------------------------------------------
// SPI buffer exchange engine package
// Beat payload types, action and link mode codes, and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package spibx_pkg;

	// Action codes carried in the input beat.
	localparam logic [2:0] ACT_WRITE = 3'd0;
	localparam logic [2:0] ACT_SEND  = 3'd1;
	localparam logic [2:0] ACT_RECV  = 3'd2;
	localparam logic [2:0] ACT_XCHG  = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	// Link mode register codes; the fourth code behaves as disabled.
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_MASTER = 2'd1;
	localparam logic [1:0] MODE_SLAVE  = 2'd2;

	// Number of distinct values of the address field.
	localparam int unsigned ADDR_SPAN = 256;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] address;
		logic [7:0] byte_value;
		logic [8:0] length;
	} spibx_in_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic [7:0] read_byte;
		logic       done_res;
		logic       overrun;
	} spibx_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOK,
		ST_NEXT,
		ST_RESP
	} spibx_state_t;

endpackage

`default_nettype wire

### src/spi_buffer_exchange_engine.sv
// Path, input beat to result register: writes, unknown actions, ignored exchanges, silent send
// starts and empty receive starts finish in ST_IDLE; reads, master send starts, slave exchanges
// and the final byte of a master transfer finish in ST_LOOK; other master exchanges in ST_NEXT.
// A non-empty receive start zeroes one entry a cycle in ST_FILL up to its saturated length.
// One item is in flight: the next beat is taken the cycle after the result is registered.
// Reset clears the controller, sets done and disables the link; the buffer is not cleared.
// ----------------------------------------------------------------------------
// SPI buffer exchange engine
// Full-duplex SPI buffer transfer controller built around one byte buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_buffer_exchange_engine #(
	parameter int unsigned BUF_DEPTH = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire spibx_pkg::spibx_in_t  in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output spibx_pkg::spibx_out_t      out_data
);

	localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [16:0] DEPTH_W = 17'(BUF_DEPTH);

	spibx_pkg::spibx_state_t state_q, state_d;
	logic [1:0]            mode_q;
	logic [8:0]            pos_q, pos_d;
	logic [8:0]            len_q, len_d;
	logic [8:0]            fill_q, fill_d;
	logic                  done_q, done_d;
	logic [2:0]            act_q;
	logic [7:0]            rx_q;
	spibx_pkg::spibx_out_t res_q, res_d, out_q;
	logic                  out_valid_q;

	logic          accept, out_free, fin, load_out;
	logic          link_on, is_master, is_slave;
	logic [8:0]    len_sat;
	logic [8:0]    pos_inc;
	logic [AW-1:0] addr_idx;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [AW-1:0] addr_map [spibx_pkg::ADDR_SPAN];

	// Address to buffer entry, folded modulo the depth at elaboration.
	for (genvar g = 0; g < spibx_pkg::ADDR_SPAN; g++) begin : g_addr_map
		assign addr_map[g] = AW'(g % BUF_DEPTH);
	end

	spibx_ram #(
		.DEPTH(BUF_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Handshake and decoded mode.
	assign in_ready  = (state_q == spibx_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign is_master = (mode_q == spibx_pkg::MODE_MASTER);
	assign is_slave  = (mode_q == spibx_pkg::MODE_SLAVE);
	assign link_on   = is_master || is_slave;
	assign addr_idx  = addr_map[in_data.address];
	assign pos_inc   = pos_q + 9'd1;

	// Transfer length saturated to the buffer depth.
	assign len_sat = ({8'd0, in_data.length} > DEPTH_W) ? 9'(BUF_DEPTH) : in_data.length;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			spibx_pkg::ST_IDLE: begin
				if (accept) begin
					if (fin) begin
						state_d = out_free ? spibx_pkg::ST_IDLE : spibx_pkg::ST_RESP;
					end else if (in_data.action == spibx_pkg::ACT_RECV) begin
						state_d = spibx_pkg::ST_FILL;
					end else begin
						state_d = spibx_pkg::ST_LOOK;
					end
				end
			end
			spibx_pkg::ST_FILL: begin
				if (fin) begin
					state_d = out_free ? spibx_pkg::ST_IDLE : spibx_pkg::ST_RESP;
				end
			end
			spibx_pkg::ST_LOOK: begin
				if (fin) begin
					state_d = out_free ? spibx_pkg::ST_IDLE : spibx_pkg::ST_RESP;
				end else begin
					state_d = spibx_pkg::ST_NEXT;
				end
			end
			spibx_pkg::ST_NEXT: begin
				state_d = out_free ? spibx_pkg::ST_IDLE : spibx_pkg::ST_RESP;
			end
			spibx_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = spibx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spibx_pkg::ST_IDLE;
			end
		endcase
	end

	// Buffer accesses, control updates and the result of the finishing step.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = rx_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		fin       = 1'b0;
		res_d     = '0;
		pos_d     = pos_q;
		len_d     = len_q;
		fill_d    = fill_q;
		done_d    = done_q;
		case (state_q)
			spibx_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_data.action)
						spibx_pkg::ACT_WRITE: begin
							ram_we    = 1'b1;
							ram_waddr = addr_idx;
							ram_wdata = in_data.byte_value;
							fin       = 1'b1;
						end
						spibx_pkg::ACT_SEND: begin
							len_d  = len_sat;
							pos_d  = '0;
							done_d = (len_sat == '0);
							if (len_sat != '0 && is_master) begin
								ram_re = 1'b1;
							end else begin
								fin = 1'b1;
							end
						end
						spibx_pkg::ACT_RECV: begin
							len_d  = len_sat;
							pos_d  = '0;
							fill_d = '0;
							done_d = (len_sat == '0);
							fin    = (len_sat == '0);
						end
						spibx_pkg::ACT_XCHG: begin
							if (!link_on || done_q || pos_q >= len_q) begin
								res_d.overrun = 1'b1;
								fin           = 1'b1;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AW'(pos_q);
							end
						end
						spibx_pkg::ACT_READ: begin
							ram_re    = 1'b1;
							ram_raddr = addr_idx;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			spibx_pkg::ST_FILL: begin
				// Zero one entry a cycle; entry 0 is then the first byte a master sends.
				ram_we    = 1'b1;
				ram_waddr = AW'(fill_q);
				ram_wdata = '0;
				fill_d    = fill_q + 9'd1;
				if (fill_q == len_q - 9'd1) begin
					fin              = 1'b1;
					res_d.send_valid = is_master;
				end
			end
			spibx_pkg::ST_LOOK: begin
				case (act_q)
					spibx_pkg::ACT_SEND: begin
						res_d.send_valid = 1'b1;
						res_d.send_byte  = ram_rdata;
						fin              = 1'b1;
					end
					spibx_pkg::ACT_READ: begin
						res_d.read_byte = ram_rdata;
						fin             = 1'b1;
					end
					spibx_pkg::ACT_XCHG: begin
						// A slave replies with the entry before it is overwritten.
						if (is_slave) begin
							res_d.send_valid = 1'b1;
							res_d.send_byte  = ram_rdata;
						end
						ram_we    = 1'b1;
						ram_waddr = AW'(pos_q);
						pos_d     = pos_inc;
						if (pos_inc >= len_q) begin
							done_d = 1'b1;
							fin    = 1'b1;
						end else if (is_master) begin
							ram_re    = 1'b1;
							ram_raddr = AW'(pos_inc);
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			spibx_pkg::ST_NEXT: begin
				res_d.send_valid = 1'b1;
				res_d.send_byte  = ram_rdata;
				fin              = 1'b1;
			end
			default: begin
			end
		endcase
		res_d.done_res = done_d;
	end

	// The result register loads from the finishing step or from the holding register.
	assign load_out = out_free && ((state_q == spibx_pkg::ST_RESP) || fin);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spibx_pkg::ST_IDLE;
			mode_q      <= spibx_pkg::MODE_OFF;
			pos_q       <= '0;
			len_q       <= '0;
			fill_q      <= '0;
			done_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
			done_q  <= done_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_data.action;
			rx_q  <= in_data.byte_value;
		end
		if (fin && !out_free) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_q <= (state_q == spibx_pkg::ST_RESP) ? res_q : res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

### src/spibx_ram.sv
// ----------------------------------------------------------------------------
// SPI buffer exchange engine byte buffer
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spibx_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/spibx_checker.sv
// ----------------------------------------------------------------------------
// SPI buffer exchange engine port checker
// Concurrent checks on the engine ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_buffer_exchange_engine_macros.svh"

module spibx_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_we,
	input wire logic [1:0]            cfg_wdata,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire spibx_pkg::spibx_in_t  in_data,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire spibx_pkg::spibx_out_t out_data
);

	logic out_stall, out_send, out_over, read_clear, send_clear;

	// Conditions on the result channel used by the checks below.
	assign out_stall  = out_valid && !out_ready;
	assign out_send   = out_valid && out_data.send_valid;
	assign out_over   = out_valid && out_data.overrun;
	assign read_clear = (out_data.read_byte == 8'd0) && !out_data.overrun;
	assign send_clear = !out_data.send_valid && (out_data.send_byte == 8'd0) &&
		(out_data.read_byte == 8'd0);

	// A stalled result beat holds its value.
	`SPIBX_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_data))

	// A result never both sends a byte and returns buffer contents.
	`SPIBX_ASSERT_NOW(a_send_or_read, clk, arst_n, out_send, read_clear)

	// An ignored exchange emits nothing.
	`SPIBX_ASSERT_NOW(a_overrun_quiet, clk, arst_n, out_over, send_clear)

endmodule

bind spi_buffer_exchange_engine spibx_checker u_spibx_checker (.*);

`default_nettype wire
